/* src/bstk_pkg.sv */
// Shared types and codes for the bounded stack with reverse.
`default_nettype none

package bstk_pkg;

  localparam int WORD_W    = 32;
  localparam int DEPTH_DEF = 32;
  localparam int CAP_W     = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // operation codes
  localparam logic [1:0] FUNC_PUSH    = 2'd0;
  localparam logic [1:0] FUNC_POP     = 2'd1;
  localparam logic [1:0] FUNC_REVERSE = 2'd2;
  localparam logic [1:0] FUNC_DISPLAY = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] read_value;
    logic                     last;
  } out_t;

endpackage

`default_nettype wire

/* src/bstk_ram.sv */
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module bstk_ram #(
  parameter int DEPTH = bstk_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [bstk_pkg::WORD_W-1:0]   wr_data,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [bstk_pkg::WORD_W-1:0]   rd_data
);

  logic [bstk_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/bounded_stack_with_reverse.sv */
// Top level of the bounded LIFO stack with in-place reverse and display walk.
//
// Input channel in_valid/in_stall carries one operation per beat: push, pop,
// reverse or display. Result channel out_valid/out_stall returns result beats;
// out_data.last marks the final beat of an operation. cfg_valid/cfg_ready
// writes the capacity register (6 bits, reset 32, values above DEPTH act as
// DEPTH); cfg_ready is always high, writes are expected only while idle.
// One operation is worked on at a time; in_stall is high from the cycle after
// an accept until the sequencer is back in idle. Push, pop and the empty or full
// reports give a single result beat. Display gives one beat a cycle while the
// receiver does not stall, from the top entry down to the bottom one. Reverse
// of n entries does floor(n/2) swaps, outermost pair first, each as: read low entry,
// read high entry, write high word to low slot, write low word to high slot;
// then one status beat. The pace of reverse and display is set by the single read
// port of the entry store, which every swap and every displayed entry must pass through.
// Reset (synchronous, rst_n low) empties the stack, drops any pending result
// beat and sets capacity to 32; stored words are not cleared. A stall on the
// result side holds the output beat and freezes the sequencer in its emit
// state, which in turn keeps in_stall high.
`default_nettype none

module bounded_stack_with_reverse #(
  parameter int DEPTH = bstk_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // operation input
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire bstk_pkg::in_t              in_data,
  // result output
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output bstk_pkg::out_t                  out_data,
  // capacity register write
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bstk_pkg::CAP_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int MW = (FW > bstk_pkg::CAP_W) ? FW : bstk_pkg::CAP_W;
  localparam int WW = bstk_pkg::WORD_W;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RESP    = 3'd1;  // single beat from res_status_r
  localparam logic [2:0] S_MEM_OUT = 3'd2;  // beat from store read data
  localparam logic [2:0] S_REV_RI  = 3'd3;  // read low entry
  localparam logic [2:0] S_REV_RJ  = 3'd4;  // read high entry, hold low
  localparam logic [2:0] S_REV_WI  = 3'd5;  // write high word to low slot
  localparam logic [2:0] S_REV_WJ  = 3'd6;  // write low word to high slot

  logic [2:0]                  state_r, state_nxt;
  logic [FW-1:0]               fill_r, fill_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;     // low / walk index
  logic [AW-1:0]               j_r, j_nxt;         // high swap index
  logic                        disp_r, disp_nxt;
  logic [1:0]                  res_status_r, res_status_nxt;
  logic [WW-1:0]               tmp_r, tmp_nxt;
  logic [bstk_pkg::CAP_W-1:0]  cap_r;
  logic                        out_valid_r, out_valid_nxt;
  bstk_pkg::out_t              out_r, out_nxt;

  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [WW-1:0]               wr_data, rd_q;

  logic                        in_acc, out_free, full, empty, mem_last;

  bstk_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  // full against the capacity in use, clamped to DEPTH
  assign full  = (MW'(fill_r) >= MW'(cap_r)) || (fill_r >= FW'(DEPTH));
  assign empty = (fill_r == '0);

  // pop gives one beat; display ends at the bottom entry
  assign mem_last = !disp_r || (idx_r == '0);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    j_nxt          = j_r;
    disp_nxt       = disp_r;
    res_status_nxt = res_status_r;
    tmp_nxt        = tmp_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            bstk_pkg::FUNC_PUSH: begin
              state_nxt = S_RESP;
              if (full) begin
                res_status_nxt = bstk_pkg::ST_FULL;
              end else begin
                res_status_nxt = bstk_pkg::ST_OK;
                wr_en          = 1'b1;
                wr_addr        = AW'(fill_r);
                wr_data        = in_data.push_value;
                fill_nxt       = fill_r + 1'b1;
              end
            end
            bstk_pkg::FUNC_POP: begin
              if (empty) begin
                res_status_nxt = bstk_pkg::ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                fill_nxt  = fill_r - 1'b1;
                rd_en     = 1'b1;
                rd_addr   = AW'(fill_r - 1'b1);
                disp_nxt  = 1'b0;
                state_nxt = S_MEM_OUT;
              end
            end
            bstk_pkg::FUNC_REVERSE: begin
              if (empty) begin
                res_status_nxt = bstk_pkg::ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                res_status_nxt = bstk_pkg::ST_OK;
                idx_nxt        = '0;
                j_nxt          = AW'(fill_r - 1'b1);
                // a single entry needs no swap
                state_nxt      = (fill_r == FW'(1)) ? S_RESP : S_REV_RI;
              end
            end
            default: begin
              if (empty) begin
                res_status_nxt = bstk_pkg::ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                idx_nxt   = AW'(fill_r - 1'b1);
                rd_en     = 1'b1;
                rd_addr   = AW'(fill_r - 1'b1);
                disp_nxt  = 1'b1;
                state_nxt = S_MEM_OUT;
              end
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.status     = res_status_r;
          out_nxt.read_value = '0;
          out_nxt.last       = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_MEM_OUT: begin
        // rd_q holds the entry at idx_r (or the popped top)
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.status     = bstk_pkg::ST_OK;
          out_nxt.read_value = rd_q;
          out_nxt.last       = mem_last;
          if (mem_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_r - 1'b1;
          end
        end
      end
      S_REV_RI: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_REV_RJ;
      end
      S_REV_RJ: begin
        rd_en     = 1'b1;
        rd_addr   = j_r;
        tmp_nxt   = rd_q;
        state_nxt = S_REV_WI;
      end
      S_REV_WI: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_q;
        state_nxt = S_REV_WJ;
      end
      S_REV_WJ: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = tmp_r;
        if ((idx_r + 1'b1) < (j_r - 1'b1)) begin
          idx_nxt   = idx_r + 1'b1;
          j_nxt     = j_r - 1'b1;
          state_nxt = S_REV_RI;
        end else begin
          state_nxt = S_RESP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= bstk_pkg::CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    j_r          <= j_nxt;
    disp_r       <= disp_nxt;
    res_status_r <= res_status_nxt;
    tmp_r        <= tmp_nxt;
    out_r        <= out_nxt;
  end

  // fill count never runs past the store
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill count beyond depth");

  // every accepted beat takes the sequencer out of idle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("sequencer still idle after accept");

  // swap indices stay ordered while reversing
  a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REV_RI || state_r == S_REV_RJ ||
     state_r == S_REV_WI || state_r == S_REV_WJ) |-> (idx_r < j_r))
    else $error("reverse indices crossed");

  // error reports carry zero data and close the operation
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != bstk_pkg::ST_OK) |->
      (out_r.read_value == '0 && out_r.last))
    else $error("malformed error beat");

  // a non-final beat only comes from a display walk
  a_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEM_OUT && out_free && !mem_last) |-> disp_r)
    else $error("multi-beat result outside display");

endmodule

`default_nettype wire
